### hw/rtl/rmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared types, constants and functions of the first-order Reed-Muller decoder.
// ----------------------------------------------------------------------------
package rmd_pkg;

    localparam int MAX_ORDER  = 6;
    localparam int WORD_BITS  = 64;
    localparam int NUM_MSG    = 128;
    localparam int NUM_LEAF   = 16;

    typedef logic signed [7:0] t_coef;
    typedef t_coef t_coef_vec [WORD_BITS];

    typedef struct packed {
        logic       valid;
        logic [6:0] msg;
        logic [6:0] hdist;
    } t_cand;

    // Clamp the configured order into the supported range.
    function automatic logic [2:0] eff_order(input logic [2:0] code);
        logic [2:0] n;
        n = code;
        if (n < 3'd1) n = 3'd1;
        if (n > 3'(MAX_ORDER)) n = 3'(MAX_ORDER);
        return n;
    endfunction

    // One butterfly layer of the Walsh-Hadamard transform.
    function automatic t_coef_vec wht_layer(input t_coef_vec x, input int k);
        t_coef_vec y;
        for (int p = 0; p < WORD_BITS; p++) begin
            if (((p >> k) & 1) == 0) begin
                y[p]            = x[p] + x[p | (1 << k)];
                y[p | (1 << k)] = x[p] - x[p | (1 << k)];
            end
        end
        return y;
    endfunction

    // Difference pattern of message v for order n: bit k is m_(n-k) xor m_(n-k-1).
    function automatic logic [5:0] msg_diff(input logic [6:0] v, input logic [2:0] n);
        logic [5:0] d;
        d = '0;
        for (int k = 0; k < MAX_ORDER; k++) begin
            if (k < int'(n)) begin
                d[k] = v[3'(int'(n) - k)] ^ v[3'(int'(n) - k - 1)];
            end
        end
        return d;
    endfunction

    // Keeps the lower-index candidate on ties.
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (!b.valid) return a;
        if (!a.valid) return b;
        if (b.hdist < a.hdist) return b;
        return a;
    endfunction

endpackage

### hw/rtl/rmd_wht.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_wht
// Two-stage pipelined 64-point Walsh-Hadamard transform of the signed word.
// ----------------------------------------------------------------------------
module rmd_wht (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [63:0]           i_word,
    input  logic [2:0]            i_order,
    output logic                  o_valid,
    output rmd_pkg::t_coef_vec    o_spec,
    output logic [2:0]            o_order
);
    import rmd_pkg::*;

    t_coef_vec n_a, r_a, n_b, r_b;
    logic      r_a_valid, r_b_valid;
    logic [2:0] r_a_order, r_b_order;

    // Positions beyond the word length contribute zero to every correlation.
    always_comb begin
        t_coef_vec x;
        for (int p = 0; p < WORD_BITS; p++) begin
            if ((p >> i_order) == 0) x[p] = i_word[p] ? -8'sd1 : 8'sd1;
            else                     x[p] = 8'sd0;
        end
        x   = wht_layer(x, 0);
        x   = wht_layer(x, 1);
        n_a = wht_layer(x, 2);
    end

    always_comb begin
        t_coef_vec y;
        y   = wht_layer(r_a, 3);
        y   = wht_layer(y, 4);
        n_b = wht_layer(y, 5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_a       <= n_a;
            r_a_order <= i_order;
            r_b       <= n_b;
            r_b_order <= r_a_order;
        end
    end

    assign o_valid = r_b_valid;
    assign o_spec  = r_b;
    assign o_order = r_b_order;
endmodule

### hw/rtl/rmd_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmd_select
// Maps spectrum values to message distances and finds the nearest message.
// ----------------------------------------------------------------------------
module rmd_select (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rmd_pkg::t_coef_vec    i_spec,
    input  logic [2:0]            i_order,
    output logic                  o_valid,
    output logic [6:0]            o_msg,
    output logic [6:0]            o_dist
);
    import rmd_pkg::*;

    t_cand n_leaf [NUM_LEAF];
    t_cand r_leaf [NUM_LEAF];
    t_cand n_best, r_best;
    logic  r_c_valid, r_d_valid;

    // Candidate distances and the first three tree levels.
    always_comb begin
        t_cand      c [NUM_MSG];
        logic [5:0] d;
        logic [8:0] len, s;
        int         w;
        len = 9'(1) << i_order;
        for (int v = 0; v < NUM_MSG; v++) begin
            d = msg_diff(7'(v), i_order);
            s = {i_spec[d][7], i_spec[d]};
            c[v].msg   = 7'(v);
            c[v].valid = ((v >> (int'(i_order) + 1)) == 0);
            if (v[int'(i_order) % 8] == 1'b0 && c[v].valid) c[v].hdist = 7'((len - s) >> 1);
            else                                            c[v].hdist = 7'((len + s) >> 1);
        end
        w = NUM_MSG;
        for (int l = 0; l < 3; l++) begin
            w = w / 2;
            for (int i = 0; i < NUM_MSG / 2; i++) begin
                if (i < w) c[i] = pick(c[2 * i], c[2 * i + 1]);
            end
        end
        for (int i = 0; i < NUM_LEAF; i++) n_leaf[i] = c[i];
    end

    always_comb begin
        t_cand t [NUM_LEAF];
        t = r_leaf;
        for (int i = 0; i < 8; i++) t[i] = pick(t[2 * i], t[2 * i + 1]);
        for (int i = 0; i < 4; i++) t[i] = pick(t[2 * i], t[2 * i + 1]);
        for (int i = 0; i < 2; i++) t[i] = pick(t[2 * i], t[2 * i + 1]);
        n_best = pick(t[0], t[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_valid;
            r_d_valid <= r_c_valid;
        end
        if (i_en) begin
            r_leaf <= n_leaf;
            r_best <= n_best;
        end
    end

    assign o_valid = r_d_valid;
    assign o_msg   = r_best.msg;
    assign o_dist  = r_best.hdist;
endmodule

### hw/rtl/reed_muller_first_order_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reed_muller_first_order_decoder_top
// Maximum-likelihood decoder for the first-order Reed-Muller code RM(1,m).
// ----------------------------------------------------------------------------
// The decoder accepts one received word per clock cycle while the output is
// not stalled and returns, for each word, the message of the nearest codeword
// and its Hamming distance. A word passes an input register, two stages of the
// 64-point Walsh-Hadamard transform (three butterfly layers each), and two
// stages of the minimum search over all 128 candidate messages. Ties go to the
// lowest message value. The whole pipeline advances together; when the output
// transaction is stalled, every stage holds and the input is not ready. The
// code order register is written over the configuration channel, which is
// always ready; orders of zero read as one and orders above six read as six.
// Write it only while the pipeline is empty.
module reed_muller_first_order_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,     // code_order
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // received_word[63:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // message_value[6:0], distance[13:7], zeros
);
    import rmd_pkg::*;

    logic [2:0]  r_order_cfg;
    logic        en;
    logic        r_in_valid;
    logic [63:0] r_in_word;
    logic [2:0]  r_in_order;
    logic        wht_valid;
    t_coef_vec   wht_spec;
    logic [2:0]  wht_order;
    logic [6:0]  sel_msg, sel_dist;

    // The pipeline moves whenever the output register is free or being read.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_cfg  <= 3'd6;
            r_in_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_order_cfg  <= i_cfg_data;
            end
            if (en) r_in_valid <= s_axis_tvalid;
        end
        if (en) begin
            r_in_word  <= s_axis_tdata;
            r_in_order <= eff_order(r_order_cfg);
        end
    end

    rmd_wht u_wht (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_valid),
        .i_word  (r_in_word),
        .i_order (r_in_order),
        .o_valid (wht_valid),
        .o_spec  (wht_spec),
        .o_order (wht_order)
    );

    rmd_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (wht_valid),
        .i_spec  (wht_spec),
        .i_order (wht_order),
        .o_valid (m_axis_tvalid),
        .o_msg   (sel_msg),
        .o_dist  (sel_dist)
    );

    assign m_axis_tdata = {2'b00, sel_dist, sel_msg};
endmodule
